// ----- rtl/core/tkst_pkg.sv -----
package tkst_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int RANK_W  = 5;
  localparam int CMP_W   = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int SCORE_W = 24;
  localparam int STAMP_W = 32;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [SCORE_W-1:0] new_score;
    logic [STAMP_W-1:0] stamp;
    logic [RANK_W-1:0]  read_rank;
  } in_t;

  typedef struct packed {
    logic [RANK_W-1:0]  placed_rank;
    logic               entry_valid;
    logic [SCORE_W-1:0] entry_score;
    logic [STAMP_W-1:0] entry_stamp;
    logic [RANK_W-1:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  function automatic logic [RANK_W-1:0] to_rank(input logic [CNT_W-1:0] v);
    logic [CNT_W+RANK_W-1:0] w;
    w = {{RANK_W{1'b0}}, v};
    return w[RANK_W-1:0];
  endfunction

endpackage

// ----- rtl/core/top_k_sorted_score_table.sv -----
// A read at a stored rank reads the score memory; a read outside the table returns an
// invalid entry. An insert into an empty table writes rank 1 directly; any other insert
// shifts lower entries down one by one, comparing each with the new score. A full table
// first checks its lowest entry and turns away a score not above it; a top score gets a place step.
// One request is in work at a time; the next is accepted once the result moves to the output.
// Synchronous active-low reset clears the entry count and out_valid; entries are kept.
module top_k_sorted_score_table (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tkst_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tkst_pkg::out_t out_data
);

  logic           seq_idle;
  logic           seq_done;
  logic           seq_take;
  tkst_pkg::out_t seq_res;
  logic           out_valid_r;
  tkst_pkg::out_t out_data_r;

  assign seq_take = seq_done && (!out_valid_r || out_ready);

  tkst_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_valid && in_ready),
    .req   (in_data),
    .take  (seq_take),
    .idle  (seq_idle),
    .done  (seq_done),
    .res   (seq_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (seq_take) begin
      out_data_r <= seq_res;
    end
  end

  assign in_ready  = seq_idle;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a request is in work");

  a_read_no_rank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.entry_valid |-> out_data_r.placed_rank == '0)
    else $error("read result carries an insert rank");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.entry_valid |->
      out_data_r.entry_score == '0 && out_data_r.entry_stamp == '0)
    else $error("invalid entry carries nonzero data");

endmodule

// ----- rtl/core/tkst_seq.sv -----
module tkst_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  tkst_pkg::in_t req,
  input  logic          take,
  output logic          idle,
  output logic          done,
  output tkst_pkg::out_t res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [tkst_pkg::CNT_W-1:0] FULL_CNT = tkst_pkg::CNT_W'(tkst_pkg::ENTRIES);
  localparam logic [tkst_pkg::IDX_W-1:0] LAST_IDX = tkst_pkg::IDX_W'(tkst_pkg::ENTRIES - 1);

  tkst_pkg::entry_t mem [tkst_pkg::ENTRIES];
  tkst_pkg::entry_t rd_data_r;

  logic [2:0]                     state_r, state_nxt;
  logic [tkst_pkg::IDX_W-1:0]     h_r, h_nxt;
  logic [tkst_pkg::CNT_W-1:0]     count_r, count_nxt;
  tkst_pkg::entry_t               new_r, new_nxt;
  tkst_pkg::out_t                 res_r, res_nxt;

  logic                           mem_we;
  logic [tkst_pkg::IDX_W-1:0]     mem_waddr;
  tkst_pkg::entry_t               mem_wdata;
  logic [tkst_pkg::IDX_W-1:0]     mem_raddr;

  logic [tkst_pkg::CMP_W-1:0]     rank_x, cnt_x, rank_m1;
  logic                           rank_ok;
  logic [tkst_pkg::CNT_W-1:0]     h_rank;

  assign rank_x  = tkst_pkg::CMP_W'(req.read_rank);
  assign cnt_x   = tkst_pkg::CMP_W'(count_r);
  assign rank_m1 = rank_x - 1'b1;
  assign rank_ok = (rank_x != '0) && (rank_x <= cnt_x);
  assign h_rank  = tkst_pkg::CNT_W'(h_r) + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    count_nxt = count_r;
    new_nxt   = new_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = h_r;
    mem_wdata = new_r;
    mem_raddr = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          new_nxt = '{score: req.new_score, stamp: req.stamp};
          res_nxt = '0;
          res_nxt.entry_count = tkst_pkg::to_rank(count_r);
          if (req.req_type == tkst_pkg::REQ_READ) begin
            if (rank_ok) begin
              mem_raddr = rank_m1[tkst_pkg::IDX_W-1:0];
              state_nxt = S_RD;
            end else begin
              state_nxt = S_DONE;
            end
          end else if (count_r == '0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{score: req.new_score, stamp: req.stamp};
            count_nxt = tkst_pkg::CNT_W'(1);
            res_nxt.placed_rank = tkst_pkg::to_rank(tkst_pkg::CNT_W'(1));
            res_nxt.entry_count = tkst_pkg::to_rank(tkst_pkg::CNT_W'(1));
            state_nxt = S_DONE;
          end else if (count_r == FULL_CNT) begin
            mem_raddr = LAST_IDX;
            state_nxt = S_CHK;
          end else begin
            h_nxt     = count_r[tkst_pkg::IDX_W-1:0];
            mem_raddr = count_r[tkst_pkg::IDX_W-1:0] - 1'b1;
            count_nxt = count_r + 1'b1;
            res_nxt.entry_count = tkst_pkg::to_rank(count_r + 1'b1);
            state_nxt = S_CMP;
          end
        end
      end
      S_CHK: begin
        h_nxt = LAST_IDX;
        if (rd_data_r.score >= new_r.score) begin
          state_nxt = S_DONE;
        end else if (LAST_IDX == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          res_nxt.placed_rank = tkst_pkg::to_rank(tkst_pkg::CNT_W'(1));
          state_nxt = S_DONE;
        end else begin
          mem_raddr = LAST_IDX - 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        mem_we = 1'b1;
        if (rd_data_r.score < new_r.score) begin
          mem_wdata = rd_data_r;
          h_nxt     = h_r - 1'b1;
          mem_raddr = h_r - 2'd2;
          if (h_r == tkst_pkg::IDX_W'(1)) begin
            state_nxt = S_PLACE;
          end
        end else begin
          res_nxt.placed_rank = tkst_pkg::to_rank(h_rank);
          state_nxt = S_DONE;
        end
      end
      S_PLACE: begin
        mem_we = 1'b1;
        res_nxt.placed_rank = tkst_pkg::to_rank(h_rank);
        state_nxt = S_DONE;
      end
      S_RD: begin
        res_nxt.entry_valid = 1'b1;
        res_nxt.entry_score = rd_data_r.score;
        res_nxt.entry_stamp = rd_data_r.stamp;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    h_r   <= h_nxt;
    new_r <= new_nxt;
    res_r <= res_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign res  = res_r;

endmodule

// ----- test/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  tkst_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  tkst_pkg::out_t out_data;

  top_k_sorted_score_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the table, updated in request order.
  logic [tkst_pkg::SCORE_W-1:0] score_tbl [tkst_pkg::ENTRIES];
  logic [tkst_pkg::STAMP_W-1:0] stamp_tbl [tkst_pkg::ENTRIES];
  int held = 0;

  tkst_pkg::in_t  queued_reqs [$];
  tkst_pkg::out_t due_results [$];

  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_cycle = 0;
  int hold_left = 0;
  int n_placed = 0;
  int n_turned_away = 0;
  int n_read_hit = 0;
  int n_read_miss = 0;
  tkst_pkg::out_t want;

  function automatic tkst_pkg::out_t table_update(tkst_pkg::in_t req);
    tkst_pkg::out_t res;
    int pos;
    res = '0;
    if (req.req_type == tkst_pkg::REQ_INSERT) begin
      if (!(held >= tkst_pkg::ENTRIES && req.new_score <= score_tbl[tkst_pkg::ENTRIES-1]))
      begin
        pos = 0;
        while (pos < held && score_tbl[pos] >= req.new_score) pos++;
        if (held < tkst_pkg::ENTRIES) held++;
        for (int i = held - 1; i > pos; i--) begin
          score_tbl[i] = score_tbl[i-1];
          stamp_tbl[i] = stamp_tbl[i-1];
        end
        score_tbl[pos] = req.new_score;
        stamp_tbl[pos] = req.stamp;
        res.placed_rank = tkst_pkg::RANK_W'(pos + 1);
        n_placed++;
      end else begin
        n_turned_away++;
      end
    end else if (req.read_rank != 0 && int'(req.read_rank) <= held) begin
      res.entry_valid = 1'b1;
      res.entry_score = score_tbl[req.read_rank - 1];
      res.entry_stamp = stamp_tbl[req.read_rank - 1];
      n_read_hit++;
    end else begin
      n_read_miss++;
    end
    res.entry_count = tkst_pkg::RANK_W'(held);
    return res;
  endfunction

  task automatic queue_insert(input logic [tkst_pkg::SCORE_W-1:0] score,
                              input logic [tkst_pkg::STAMP_W-1:0] stamp);
    tkst_pkg::in_t req;
    req.req_type  = tkst_pkg::REQ_INSERT;
    req.new_score = score;
    req.stamp     = stamp;
    req.read_rank = tkst_pkg::RANK_W'($urandom);
    queued_reqs.push_back(req);
  endtask

  task automatic queue_read(input int rank);
    tkst_pkg::in_t req;
    req.req_type  = tkst_pkg::REQ_READ;
    req.new_score = tkst_pkg::SCORE_W'($urandom);
    req.stamp     = $urandom;
    req.read_rank = tkst_pkg::RANK_W'(rank);
    queued_reqs.push_back(req);
  endtask

  // Sender: bursts of requests separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(table_update(in_data));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (queued_reqs.size() > 0) begin
          in_data  <= queued_reqs.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25)
                                                   : $urandom_range(0, 3);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a stall pattern that steps through four modes in turn, plus one
  // long hold-off that lets the block back up and stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 1500) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case ((rx_cycle / 300) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rx_cycle % 5 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: %p", out_data);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_data.placed_rank !== want.placed_rank) begin
          $error("placed_rank: expected %0d, got %0d", want.placed_rank, out_data.placed_rank);
          errors++;
        end
        if (out_data.entry_valid !== want.entry_valid) begin
          $error("entry_valid: expected %0d, got %0d", want.entry_valid, out_data.entry_valid);
          errors++;
        end
        if (out_data.entry_score !== want.entry_score) begin
          $error("entry_score: expected %0h, got %0h", want.entry_score, out_data.entry_score);
          errors++;
        end
        if (out_data.entry_stamp !== want.entry_stamp) begin
          $error("entry_stamp: expected %0h, got %0h", want.entry_stamp, out_data.entry_stamp);
          errors++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_data.entry_count);
          errors++;
        end
      end
    end
  end

  initial begin
    int level;
    int pick;
    int rank;

    queue_read(0);
    queue_read(1);
    queue_read(31);
    queue_insert('0, '0);
    queue_insert('1, '1);
    queue_insert('1, 32'h1234_5678);
    queue_insert('0, 32'hA5A5_A5A5);
    queue_insert(24'h80_0000, 32'h0000_0001);
    queue_insert(24'h00_0001, 32'h5A5A_5A5A);
    for (int r = 1; r <= 6; r++) queue_read(r);
    queue_read(16);
    queue_read(17);
    queue_read(31);
    queue_read(0);

    // Scores mostly fall in a narrow band that moves up now and then, so the
    // table fills, ties are common and the lowest entry keeps being contested.
    level = 0;
    for (int n = 0; n < 1300; n++) begin
      if (n % 80 == 79) begin
        level = level + $urandom_range(0, (24'hFF_FFFF - level) / 6);
        if (level > 24'hFF_FFFF - 16) level = 24'hFF_FFFF - 16;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        rank = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                           : $urandom_range(0, tkst_pkg::ENTRIES + 1);
        queue_read(rank);
      end else if (pick < 88) begin
        queue_insert(tkst_pkg::SCORE_W'(level + $urandom_range(0, 15)), $urandom);
      end else if (pick < 96) begin
        queue_insert(tkst_pkg::SCORE_W'($urandom), $urandom);
      end else begin
        queue_insert('0, $urandom);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_reqs.size() != 0 || in_valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (tkst_pkg::ENTRIES + 8) @(posedge clk);

    $display("Checked %0d inserts placed and %0d turned away by a full table,",
             n_placed, n_turned_away);
    $display("and %0d reads at a stored rank and %0d reads outside the table.",
             n_read_hit, n_read_miss);
    if (errors == 0) begin
      $display("PASS top_k_sorted_score_table");
    end else begin
      $display("FAIL top_k_sorted_score_table");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL top_k_sorted_score_table");
    $finish;
  end

endmodule
